[hw/rtl/fsr_pkg.sv]
// ----------------------------------------------------------------------------
// fsr_pkg: shared types and constants of the fixed-point square root
// Widths, iteration counts and the record that moves from cell to cell.
// ----------------------------------------------------------------------------
package fsr_pkg;

  localparam int DATA_W     = 32;
  localparam int ROOT_W     = 24;
  localparam int FRAC_W     = 5;
  localparam int FRAC_MAX   = 16;
  localparam int BASE_ITERS = DATA_W / 2;
  localparam int MAX_ITERS  = BASE_ITERS + FRAC_MAX / 2;
  localparam int ITER_W     = $clog2(MAX_ITERS + 1);
  localparam int EXTRA_W    = $clog2(FRAC_MAX / 2 + 1);
  // The remainder never exceeds twice the root; two bits are brought down.
  localparam int REM_W      = ROOT_W + 4;

  typedef logic [DATA_W-1:0]  radicand_t;
  typedef logic [ROOT_W-1:0]  root_t;
  typedef logic [FRAC_W-1:0]  frac_t;
  typedef logic [EXTRA_W-1:0] extra_t;
  typedef logic [ITER_W-1:0]  iter_t;
  typedef logic [REM_W-1:0]   rem_t;

  typedef struct packed {
    rem_t      rem_hi;
    radicand_t rem_lo;
    root_t     root;
    extra_t    extra;
  } stage_t;

  // Extra iterations for a fraction setting: saturate at FRAC_MAX, then halve.
  function automatic extra_t extra_iters(frac_t fb);
    frac_t sat;
    sat = (fb > frac_t'(FRAC_MAX)) ? frac_t'(FRAC_MAX) : fb;
    return extra_t'(sat >> 1);
  endfunction

endpackage

[hw/rtl/fsr_if.sv]
// ----------------------------------------------------------------------------
// fsr_if: valid/ready channels of the fixed-point square root
// One interface for the radicand items and one for the root items.
// ----------------------------------------------------------------------------
interface fsr_in_if import fsr_pkg::*; ();
  logic      valid;
  logic      ready;
  radicand_t radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

interface fsr_out_if import fsr_pkg::*; ();
  logic  valid;
  logic  ready;
  root_t root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

[hw/rtl/fsr_cell.sv]
// ----------------------------------------------------------------------------
// fsr_cell: one iteration of the digit-by-digit square root
// Holds one item, performs one restoring step on it when its position is
// inside the item's iteration count, and hands it to the next cell.
// ----------------------------------------------------------------------------
module fsr_cell import fsr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  iter_t  idx,
  input  logic   up_valid,
  output logic   up_ready,
  input  stage_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output stage_t dn_data
);

  logic   valid_r;
  logic   valid_nxt;
  stage_t data_r;
  stage_t data_nxt;
  logic   active;
  rem_t   hi_sh;
  rem_t   test;
  root_t  root_sh;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    active   = idx < (iter_t'(BASE_ITERS) + iter_t'(up_data.extra));
    hi_sh    = {up_data.rem_hi[REM_W-3:0], up_data.rem_lo[DATA_W-1 -: 2]};
    root_sh  = {up_data.root[ROOT_W-2:0], 1'b0};
    test     = rem_t'({root_sh, 1'b1});
    data_nxt = up_data;
    if (active) begin
      data_nxt.rem_lo = up_data.rem_lo << 2;
      if (hi_sh >= test) begin
        data_nxt.rem_hi = hi_sh - test;
        data_nxt.root   = root_sh | root_t'(1);
      end else begin
        data_nxt.rem_hi = hi_sh;
        data_nxt.root   = root_sh;
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

[hw/rtl/fixed_point_square_root.sv]
// ----------------------------------------------------------------------------
// fixed_point_square_root: pipelined fixed-point square root
// A row of identical cells, one restoring digit-by-digit step each.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                 Handshake
// in_ch     in   radicand [31:0]         valid/ready
// out_ch    out  root [23:0]             valid/ready
// cfg       in   cfg_wr_data [4:0]       cfg_wr_en, no wait
//
// One item enters per cycle unless the result side stalls; every item passes
// through all 24 cells on its way from acceptance to the result appearing.
// The last cell is the output register. Cells that lie beyond an item's
// iteration count pass it through unchanged.
// Each cell takes a new item when it is empty or its neighbor takes its
// item, so bubbles close up while the result side stalls.
// Synchronous active-low reset empties all cells and sets frac_bits to 16.
// ----------------------------------------------------------------------------
module fixed_point_square_root import fsr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  fsr_in_if.sink           in_ch,
  fsr_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  frac_t            cfg_wr_data
);

  frac_t  frac_r;
  frac_t  frac_nxt;
  logic   vld   [MAX_ITERS+1];
  logic   rdy   [MAX_ITERS+1];
  stage_t data  [MAX_ITERS+1];
  stage_t last;

  always_comb begin
    frac_nxt = frac_r;
    if (cfg_wr_en) begin
      frac_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= frac_t'(FRAC_MAX);
    end else begin
      frac_r <= frac_nxt;
    end
  end

  assign vld[0]         = in_ch.valid;
  assign in_ch.ready    = rdy[0];
  assign data[0].rem_hi = '0;
  assign data[0].rem_lo = in_ch.radicand;
  assign data[0].root   = '0;
  assign data[0].extra  = extra_iters(frac_r);

  for (genvar k = 0; k < MAX_ITERS; k++) begin : g_cell
    fsr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (iter_t'(k)),
      .up_valid (vld[k]),
      .up_ready (rdy[k]),
      .up_data  (data[k]),
      .dn_valid (vld[k+1]),
      .dn_ready (rdy[k+1]),
      .dn_data  (data[k+1])
    );
  end

  assign last          = data[MAX_ITERS];
  assign rdy[MAX_ITERS] = out_ch.ready;
  assign out_ch.valid  = vld[MAX_ITERS];
  assign out_ch.root   = last.root;

  // An accepted item always lands in the first cell.
  a_first_cell_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld[1])
    else $error("accepted item did not enter the first cell");

  // The finished root has no more bits than iterations were run.
  a_root_width: assert property (@(posedge clk) disable iff (!rst_n)
    vld[MAX_ITERS] |->
      ((ROOT_W+1)'(last.root) >> (iter_t'(BASE_ITERS) + iter_t'(last.extra))) == '0)
    else $error("root wider than its iteration count");

  // Restoring step invariant: remainder never exceeds twice the root.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld[MAX_ITERS] |-> last.rem_hi <= rem_t'({last.root, 1'b0}))
    else $error("remainder exceeds twice the root");

  // The iteration extension never passes its saturated maximum.
  a_extra_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld[MAX_ITERS] |-> last.extra <= extra_t'(FRAC_MAX / 2))
    else $error("iteration extension out of range");

endmodule

[dv/fixed_point_square_root_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_point_square_root_test: self-checking bench for the square root
// A short table of hand-picked radicands and fraction settings runs first.
// Random radicands under several fraction settings follow. Roots are checked
// against a bit-true restoring square root, while the sender idles in bursts
// and the receiver stalls.
// ----------------------------------------------------------------------------
module fixed_point_square_root_test;
  import fsr_pkg::*;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

  typedef struct packed {
    logic      has_cfg;
    frac_t     cfg;
    radicand_t x;
    logic      known;
    root_t     want;
  } sqrt_row_t;

  localparam int ITEMS_PER_SETTING = 70;
  localparam int IDLE_LIMIT        = 4000;
  localparam int SETTLE_CYCLES     = 40;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  cfg_wr_en;
  frac_t cfg_wr_data;

  fsr_in_if  in_ch ();
  fsr_out_if out_ch ();

  fixed_point_square_root dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  root_t    root_q [$];
  frac_t    frac_now = 5'd16;
  int       errors = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_count = 0;

  // Known roots are typed in; rows with known = 0 go to the predictor.
  sqrt_row_t directed_rows [23] = '{
    '{1'b0, 5'd0,  32'h0001_0000, 1'b1, 24'h010000},  // 1.0 after reset
    '{1'b0, 5'd0,  32'h0000_0000, 1'b1, 24'h000000},
    '{1'b0, 5'd0,  32'hFFFF_FFFF, 1'b1, 24'hFFFFFF},
    '{1'b0, 5'd0,  32'h0004_0000, 1'b1, 24'h020000},
    '{1'b0, 5'd0,  32'h0000_0001, 1'b0, 24'h000000},
    '{1'b0, 5'd0,  32'h8000_0000, 1'b0, 24'h000000},
    '{1'b1, 5'd0,  32'h0000_0000, 1'b1, 24'h000000},
    '{1'b0, 5'd0,  32'h0000_0001, 1'b1, 24'h000001},
    '{1'b0, 5'd0,  32'hFFFF_FFFF, 1'b1, 24'h00FFFF},
    '{1'b0, 5'd0,  32'hFFFE_0001, 1'b1, 24'h00FFFF},
    '{1'b0, 5'd0,  32'hFFFE_0000, 1'b1, 24'h00FFFE},
    '{1'b0, 5'd0,  32'h5555_5555, 1'b0, 24'h000000},
    '{1'b0, 5'd0,  32'hAAAA_AAAA, 1'b0, 24'h000000},
    '{1'b1, 5'd31, 32'hFFFF_FFFF, 1'b1, 24'hFFFFFF},  // saturates to 16
    '{1'b0, 5'd0,  32'h0001_0000, 1'b1, 24'h010000},
    '{1'b0, 5'd0,  32'h1234_5678, 1'b0, 24'h000000},
    '{1'b1, 5'd17, 32'h0009_0000, 1'b1, 24'h030000},
    '{1'b1, 5'd1,  32'h0000_0010, 1'b1, 24'h000004},  // odd, same as 0
    '{1'b0, 5'd0,  32'hFFFF_FFFF, 1'b1, 24'h00FFFF},
    '{1'b1, 5'd15, 32'hFFFF_FFFF, 1'b0, 24'h000000},
    '{1'b0, 5'd0,  32'h0000_0002, 1'b0, 24'h000000},
    '{1'b1, 5'd8,  32'h0000_0100, 1'b1, 24'h000100},
    '{1'b0, 5'd0,  32'h7FFF_FFFF, 1'b0, 24'h000000}
  };

  frac_t phase_fracs [7] = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd15, 5'd17, 5'd8};

  // Restoring square root over a wide remainder, one root bit per step.
  function automatic root_t predict_root(radicand_t x, frac_t fb);
    logic [63:0] rem;
    logic [63:0] acc;
    logic [63:0] trial;
    radicand_t   pending;
    int          steps;
    rem     = '0;
    acc     = '0;
    pending = x;
    steps   = DATA_W / 2 + ((fb > frac_t'(FRAC_MAX)) ? FRAC_MAX : int'(fb)) / 2;
    for (int i = 0; i < steps; i++) begin
      rem     = {rem[61:0], pending[DATA_W-1 -: 2]};
      pending = pending << 2;
      acc     = acc << 1;
      trial   = {acc[62:0], 1'b1};
      if (rem >= trial) begin
        rem = rem - trial;
        acc = acc + 64'd1;
      end
    end
    return acc[ROOT_W-1:0];
  endfunction

  function automatic radicand_t pick_radicand();
    radicand_t s;
    case ($urandom_range(0, 6))
      0, 1: pick_radicand = $urandom;
      2: pick_radicand = $urandom_range(0, 255);
      3: begin
        s = $urandom_range(0, 65535);
        pick_radicand = s * s + $urandom_range(0, 2) - 1;
      end
      4: pick_radicand = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
      5: pick_radicand = 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: pick_radicand = $urandom & ~(32'hFFFF_FFFF << $urandom_range(1, 31));
    endcase
  endfunction

  // The sender idles between bursts; a long burst gives a stretch with no gaps.
  task automatic send_item(radicand_t x, logic known, root_t want);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_ch.valid    <= 1'b1;
    in_ch.radicand <= x;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    root_q.push_back(known ? want : predict_root(x, frac_now));
    burst_left--;
  endtask

  // The register is only written once every root in flight has come out.
  task automatic write_frac(frac_t v);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (root_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frac_now = v;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_count == 0) begin
        rx_mode  <= rx_mode_t'($urandom_range(0, 3));
        rx_count <= $urandom_range(16, 96);
      end else begin
        rx_count <= rx_count - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= $urandom_range(0, 1);
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   out_ch.ready <= rx_count[3];
      endcase
    end
  end

  always @(posedge clk) begin
    root_t exp_root;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (root_q.size() == 0) begin
        $error("root item with no expectation: actual %h", out_ch.root);
        errors++;
      end else begin
        exp_root = root_q.pop_front();
        if (out_ch.root !== exp_root) begin
          $error("root mismatch: expected %h, actual %h", exp_root, out_ch.root);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $error("no item moved for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.radicand <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].has_cfg) begin
        write_frac(directed_rows[i].cfg);
      end
      send_item(directed_rows[i].x, directed_rows[i].known, directed_rows[i].want);
    end

    for (int p = 0; p < 10; p++) begin
      write_frac((p < 7) ? phase_fracs[p] : frac_t'($urandom_range(0, 31)));
      repeat (ITEMS_PER_SETTING) send_item(pick_radicand(), 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (root_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (root_q.size() != 0) begin
      $error("%0d roots never arrived", root_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
